>>> design/wbmf_pkg.sv
// Package for the word-boundary message fragmenter: transaction payload types
// and fixed codes shared by the core and its checker.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package wbmf_pkg;

    // Field widths fixed by the interface.
    localparam int SENDER_W = 2;
    localparam int RCP_W    = 2;
    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int CFG_W    = 6;

    // Command codes.
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_END    = 1'b1;

    // Chunk kind codes.
    localparam logic [KIND_W-1:0] KIND_UNFRAG = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CONT   = 2'd2;

    // Word separator and the chunk limit after reset.
    localparam logic [CHAR_W-1:0] SPACE_CHAR        = 8'h20;
    localparam logic [CFG_W-1:0]  CHUNK_LIMIT_RESET = 6'd32;

    // Input transaction.
    typedef struct packed {
        logic                cmd;
        logic [SENDER_W-1:0] sender;
        logic [CHAR_W-1:0]   char_in;
        logic [RCP_W-1:0]    recipient;
    } in_item_t;

    // Result transaction.
    typedef struct packed {
        logic [SENDER_W-1:0] from_port;
        logic [RCP_W-1:0]    to_port;
        logic [KIND_W-1:0]   chunk_kind;
        logic                char_valid;
        logic [CHAR_W-1:0]   char_out;
        logic                chunk_end;
        logic                last;
    } out_item_t;

endpackage

`default_nettype wire

>>> design/wbmf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-sender message buffers; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module wbmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 192
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/word_boundary_message_fragmenter_core.sv
// Word-boundary message fragmenter: per-sender byte buffers, greedy word-wrap
// chunking and per-character result stream. Uses wbmf_pkg and wbmf_ram.
//
// Usage:
//   The input channel (s_valid/s_ready/s_data) carries append and end
//   transactions. An append stores one byte in the sender's buffer;
//   bytes beyond BUFFER_BYTES are dropped. An end transaction
//   walks the stored message and emits one result transaction per character
//   (or one marker per empty chunk) on m_valid/m_ready/m_data; it empties that
//   sender's buffer when taken. s_ready is low while a message is being emitted.
//   Each emitted character passes through the buffer RAM's registered read
//   and the output register; the next one is read after the result is taken.
//   Each chunk adds a setup state; a chunk that must be wrapped adds a
//   backward space search, one RAM read per cycle through the same port.
//   Reset clears the fill counts of all buffers, the sequencer and the output
//   valid, and sets chunk_limit to 32; buffer contents are not cleared.
//   When the receiver stalls, the current result holds in the output register
//   and the sequencer waits. cfg_wr_en writes chunk_limit; the user must use it
//   only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module word_boundary_message_fragmenter_core #(
    parameter int BUFFER_BYTES = 64,
    parameter int CHUNK_MAX    = 32,
    parameter int PORTS        = 3
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire wbmf_pkg::in_item_t        s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output wbmf_pkg::out_item_t            m_data,
    input  wire logic                      cfg_wr_en,
    input  wire logic [wbmf_pkg::CFG_W-1:0] cfg_wr_data
);

    import wbmf_pkg::*;

    localparam int LW    = $clog2(BUFFER_BYTES + 1);
    localparam int IW    = $clog2(BUFFER_BYTES);
    localparam int LIMW  = $clog2(CHUNK_MAX + 1);
    localparam int NW    = (LW > LIMW) ? LW : LIMW;
    localparam int GW    = (NW > CFG_W) ? NW + 1 : CFG_W + 1;
    localparam int PW    = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int DEPTH = PORTS * BUFFER_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [SENDER_W:0] PORTS_CNT = (SENDER_W + 1)'(PORTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHUNK,
        ST_SCAN,
        ST_LOAD,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    cfg_limit_reg;
    logic [LW-1:0]       len_reg  [PORTS];
    logic [LW-1:0]       len_next [PORTS];
    logic [SENDER_W-1:0] snd_reg, snd_next;
    logic [RCP_W-1:0]    rcp_reg, rcp_next;
    logic [NW-1:0]       lim_reg, lim_next;
    logic [NW-1:0]       ptr_reg, ptr_next;
    logic [NW-1:0]       rem_reg, rem_next;
    logic [NW-1:0]       take_reg, take_next;
    logic [NW-1:0]       cnt_reg, cnt_next;
    logic [NW-1:0]       scan_reg, scan_next;
    logic                skip_reg, skip_next;
    logic                nsp_reg, nsp_next;
    logic                frag_reg, frag_next;
    logic                first_reg, first_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [CHAR_W-1:0]   ram_rdata;
    logic [NW-1:0]       rd_off;

    logic [PW-1:0]       sel;
    logic                sender_ok;
    logic [NW-1:0]       lim_val;
    logic [NW-1:0]       cur_len;
    logic [KIND_W-1:0]   item_kind;
    logic [NW-1:0]       rem_after;
    logic [NW-1:0]       rem_left;
    logic                chunk_last;
    logic                ld_end;
    logic                is_space;

    // Flat buffer address of one byte of one sender's buffer.
    function automatic logic [AW-1:0] buf_addr(input logic [SENDER_W-1:0] port,
                                               input logic [IW-1:0] idx);
        return AW'(port) * AW'(BUFFER_BYTES) + AW'(idx);
    endfunction

    // Message buffers of all senders.
    wbmf_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_data.char_in),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Input decode and the clamped chunk limit.
    assign sel       = s_data.sender[PW-1:0];
    assign sender_ok = ({1'b0, s_data.sender} < PORTS_CNT);
    assign cur_len   = sender_ok ? NW'(len_reg[sel]) : '0;
    assign lim_val   = (cfg_limit_reg == '0) ? NW'(1) :
                       (GW'(cfg_limit_reg) > GW'(CHUNK_MAX)) ? NW'(CHUNK_MAX) :
                       NW'(cfg_limit_reg);

    // Per-chunk bookkeeping used when results are built and a chunk closes.
    assign item_kind  = frag_reg ? (first_reg ? KIND_FIRST : KIND_CONT) : KIND_UNFRAG;
    assign rem_after  = rem_reg - take_reg;
    assign rem_left   = rem_after - NW'(skip_reg);
    assign chunk_last = (rem_after == '0) || ((rem_after == NW'(1)) && skip_reg);
    assign ld_end     = (take_reg == '0) || ((cnt_reg + NW'(1)) == take_reg);
    assign is_space   = (ram_rdata == SPACE_CHAR);

    // Sequencer: append, chunk setup, backward space search and emission.
    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        snd_next     = snd_reg;
        rcp_next     = rcp_reg;
        lim_next     = lim_reg;
        ptr_next     = ptr_reg;
        rem_next     = rem_reg;
        take_next    = take_reg;
        cnt_next     = cnt_reg;
        scan_next    = scan_reg;
        skip_next    = skip_reg;
        nsp_next     = nsp_reg;
        frag_next    = frag_reg;
        first_next   = first_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = buf_addr(s_data.sender, IW'(cur_len));
        ram_re       = 1'b0;
        rd_off       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && sender_ok) begin
                    if (s_data.cmd == CMD_APPEND) begin
                        if (len_reg[sel] < LW'(BUFFER_BYTES)) begin
                            ram_we        = 1'b1;
                            len_next[sel] = len_reg[sel] + LW'(1);
                        end
                    end else if (len_reg[sel] != '0) begin
                        snd_next      = s_data.sender;
                        rcp_next      = s_data.recipient;
                        lim_next      = lim_val;
                        rem_next      = cur_len;
                        ptr_next      = '0;
                        frag_next     = (cur_len > lim_val);
                        first_next    = 1'b1;
                        len_next[sel] = '0;
                        state_next    = ST_CHUNK;
                    end
                end
            end
            ST_CHUNK: begin
                ram_re = 1'b1;
                if (rem_reg <= lim_reg) begin
                    take_next  = rem_reg;
                    skip_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end else begin
                    rd_off     = lim_reg;
                    scan_next  = lim_reg;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_reg == lim_reg) begin
                    // Byte just past the window decides a skip after a hard split.
                    nsp_next  = is_space;
                    ram_re    = 1'b1;
                    rd_off    = scan_reg - NW'(1);
                    scan_next = scan_reg - NW'(1);
                end else if (is_space) begin
                    take_next  = scan_reg;
                    skip_next  = 1'b1;
                    cnt_next   = '0;
                    ram_re     = 1'b1;
                    state_next = ST_LOAD;
                end else if (scan_reg == '0) begin
                    take_next  = lim_reg;
                    skip_next  = nsp_reg;
                    cnt_next   = '0;
                    ram_re     = 1'b1;
                    state_next = ST_LOAD;
                end else begin
                    ram_re    = 1'b1;
                    rd_off    = scan_reg - NW'(1);
                    scan_next = scan_reg - NW'(1);
                end
            end
            ST_LOAD: begin
                m_valid_next           = 1'b1;
                m_data_next.from_port  = snd_reg;
                m_data_next.to_port    = rcp_reg;
                m_data_next.chunk_kind = item_kind;
                m_data_next.char_valid = (take_reg != '0);
                m_data_next.char_out   = (take_reg != '0) ? ram_rdata : '0;
                m_data_next.chunk_end  = ld_end;
                m_data_next.last       = ld_end && chunk_last;
                state_next             = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (!ld_end) begin
                        cnt_next   = cnt_reg + NW'(1);
                        ram_re     = 1'b1;
                        rd_off     = cnt_reg + NW'(1);
                        state_next = ST_LOAD;
                    end else begin
                        ptr_next   = ptr_reg + take_reg + NW'(skip_reg);
                        rem_next   = rem_left;
                        first_next = 1'b0;
                        state_next = (rem_left == '0) ? ST_IDLE : ST_CHUNK;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        ram_raddr = buf_addr(snd_reg, IW'(ptr_reg + rd_off));
    end

    // State, control and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_limit_reg <= CHUNK_LIMIT_RESET;
            m_valid_reg   <= 1'b0;
            for (int p = 0; p < PORTS; p++) begin
                len_reg[p] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            len_reg     <= len_next;
            if (cfg_wr_en) begin
                cfg_limit_reg <= cfg_wr_data;
            end
        end
        snd_reg    <= snd_next;
        rcp_reg    <= rcp_next;
        lim_reg    <= lim_next;
        ptr_reg    <= ptr_next;
        rem_reg    <= rem_next;
        take_reg   <= take_next;
        cnt_reg    <= cnt_next;
        scan_reg   <= scan_next;
        skip_reg   <= skip_next;
        nsp_reg    <= nsp_next;
        frag_reg   <= frag_next;
        first_reg  <= first_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

>>> design/wbmf_checker.sv
// Port-level checker for the word-boundary message fragmenter and the bind
// that attaches it to the core. Uses wbmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbmf_checker (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_ready,
    input  wire logic                       m_valid,
    input  wire logic                       m_ready,
    input  wire wbmf_pkg::out_item_t        m_data
);

    import wbmf_pkg::*;

    // A stalled result transaction stays offered and unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction dropped or changed while stalled");

    // No new input transaction is taken while a result is being emitted.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while a message is being emitted");

    // An empty-chunk marker carries no byte and closes its chunk.
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.char_valid |-> m_data.chunk_end && (m_data.char_out == '0))
        else $error("malformed empty-chunk marker");

    // The final transaction of a message also closes its chunk.
    a_last_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> m_data.chunk_end)
        else $error("message end without chunk end");

    // Chunk kind is never the unused code.
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.chunk_kind == KIND_UNFRAG) ||
                    (m_data.chunk_kind == KIND_FIRST) ||
                    (m_data.chunk_kind == KIND_CONT))
        else $error("invalid chunk kind");

endmodule

bind word_boundary_message_fragmenter_core wbmf_checker u_wbmf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data)
);

`default_nettype wire
